// ===== hw/rtl/apsr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package apsr_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic CFG_CAPTURE_ENABLE = 1'b0;

    typedef enum logic [2:0] {
        OP_OPEN    = 3'd0,
        OP_LOOKUP  = 3'd1,
        OP_CONFIG  = 3'd2,
        OP_RELEASE = 3'd3,
        OP_FLUSH   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ACT_NONE      = 2'd0,
        ACT_OPEN      = 2'd1,
        ACT_CLOSE     = 2'd2,
        ACT_CLOSE_ALL = 2'd3
    } act_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] process_id;
        logic [7:0]  port_number;
        logic [15:0] frames;
        logic [17:0] rate;
        logic [7:0]  mode;
        logic        keep_frames;
        logic        keep_rate;
        logic        keep_mode;
        logic        mixer_open_ok;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [2:0]  slot_index;
        logic [15:0] frames_out;
        logic [31:0] generation_out;
        logic [1:0]  mixer_action;
        logic [17:0] rate_out;
        logic [7:0]  mode_out;
    } rsp_t;

    typedef struct packed {
        logic [31:0] pid;
        logic [7:0]  port;
        logic [15:0] frames;
        logic [17:0] rate;
        logic [7:0]  mode;
        logic [31:0] generation;
    } entry_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic exec;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
    } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/apsr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface apsr_req_if;
    logic          valid;
    logic          ready;
    apsr_pkg::req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface apsr_rsp_if;
    logic          valid;
    logic          ready;
    apsr_pkg::rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/audio_port_source_registry.sv =====
// An accepted beat passes through the slot scan, an execute state and a response state;
// no new beat is accepted until its response is taken. The slot scan reads one table
// entry per cycle through a registered port.
// Reset clears all slot valid bits, the generation counter and capture_enable at once;
// no clearing pass is needed and a beat can be accepted in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module audio_port_source_registry #(
    parameter int SLOT_COUNT = apsr_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    apsr_req_if.sink                          req,
    apsr_rsp_if.source                        rsp,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [apsr_pkg::PADDR_W-1:0] paddr,
    input  wire logic [apsr_pkg::PDATA_W-1:0] pwdata,
    output logic [apsr_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    logic              capture_enable_reg;
    logic              cfg_hit;
    apsr_pkg::cmd_t    cmd;
    apsr_pkg::status_t status;

    assign pready  = 1'b1;
    assign cfg_hit = paddr[2] == apsr_pkg::CFG_CAPTURE_ENABLE;
    assign prdata  = cfg_hit ? {{(apsr_pkg::PDATA_W-1){1'b0}}, capture_enable_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capture_enable_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && cfg_hit)
        begin
            capture_enable_reg <= pwdata[0];
        end
    end

    apsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .status    (status)
    );

    apsr_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .req_payload    (req.payload),
        .capture_enable (capture_enable_reg),
        .rsp_payload    (rsp.payload)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/apsr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module apsr_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output apsr_pkg::cmd_t         cmd,
    input  wire apsr_pkg::status_t status
);

    apsr_pkg::state_t state_reg;
    apsr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= apsr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        rsp_valid  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            apsr_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = apsr_pkg::ST_SCAN;
                end
            end
            apsr_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = apsr_pkg::ST_EXEC;
                end
            end
            apsr_pkg::ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = apsr_pkg::ST_RESP;
            end
            apsr_pkg::ST_RESP:
            begin
                rsp_valid = 1'b1;
                if (rsp_ready)
                begin
                    state_next = apsr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = apsr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/apsr_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module apsr_dp #(
    parameter int SLOT_COUNT = apsr_pkg::SLOT_COUNT_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire apsr_pkg::cmd_t  cmd,
    output apsr_pkg::status_t    status,
    input  wire apsr_pkg::req_t  req_payload,
    input  wire logic            capture_enable,
    output apsr_pkg::rsp_t       rsp_payload
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(SLOT_COUNT);

    apsr_pkg::entry_t mem [SLOT_COUNT];

    apsr_pkg::req_t   req_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             rd_valid_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    apsr_pkg::entry_t mem_q_reg;
    logic             vq_reg;
    logic [SLOT_COUNT-1:0] valid_reg;
    logic [31:0]      gen_reg;

    logic             found_reg;
    logic [IDX_W-1:0] found_idx_reg;
    apsr_pkg::entry_t found_ent_reg;
    logic             free_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [IDX_W-1:0] low_idx_reg;
    logic [31:0]      low_gen_reg;
    apsr_pkg::rsp_t   rsp_reg;

    logic             issue;
    logic [IDX_W-1:0] rd_addr;
    apsr_pkg::entry_t ent_eff;
    logic             in_use;
    logic             key_match;

    logic [IDX_W-1:0] pick_idx;
    logic [31:0]      gen_inc;
    logic [31:0]      gen_fresh;
    logic [15:0]      nf;
    logic [17:0]      nr;
    logic [7:0]       nm;
    logic             do_reopen;
    logic [IDX_W-1:0] ro_idx;
    logic [15:0]      ro_f;
    logic [17:0]      ro_r;
    logic [7:0]       ro_m;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    apsr_pkg::entry_t wr_data;
    logic             wr_valid;
    logic             flush;
    logic             gen_upd;
    apsr_pkg::rsp_t   rsp_next;

    assign issue            = cmd.scan && (cnt_reg < CNT_END);
    assign rd_addr          = cnt_reg[IDX_W-1:0];
    assign status.scan_done = cmd.scan && !issue && !rd_valid_reg;
    assign rsp_payload      = rsp_reg;

    assign ent_eff   = vq_reg ? mem_q_reg : '0;
    assign in_use    = ent_eff.frames != 16'd0;
    assign key_match = (ent_eff.pid == req_reg.process_id)
                    && (ent_eff.port == req_reg.port_number);

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            mem_q_reg <= mem[rd_addr];
            vq_reg    <= valid_reg[rd_addr];
        end
        if (cmd.exec && wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (cmd.start)
        begin
            req_reg <= req_payload;
        end
        if (cmd.exec)
        begin
            rsp_reg <= rsp_next;
        end
        if (rd_valid_reg)
        begin
            if (!found_reg && in_use && key_match)
            begin
                found_idx_reg <= rd_idx_reg;
                found_ent_reg <= ent_eff;
            end
            if (!free_reg && !in_use)
            begin
                free_idx_reg <= rd_idx_reg;
            end
            if ((rd_idx_reg == '0) || (ent_eff.generation < low_gen_reg))
            begin
                low_idx_reg <= rd_idx_reg;
                low_gen_reg <= ent_eff.generation;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            rd_valid_reg <= 1'b0;
            rd_idx_reg   <= '0;
            valid_reg    <= '0;
            gen_reg      <= '0;
            found_reg    <= 1'b0;
            free_reg     <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= issue;
            rd_idx_reg   <= rd_addr;
            if (cmd.start)
            begin
                cnt_reg   <= '0;
                found_reg <= 1'b0;
                free_reg  <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                if (rd_valid_reg && in_use && key_match)
                begin
                    found_reg <= 1'b1;
                end
                if (rd_valid_reg && !in_use)
                begin
                    free_reg <= 1'b1;
                end
            end
            if (cmd.exec)
            begin
                if (flush)
                begin
                    valid_reg <= '0;
                end
                else if (wr_en)
                begin
                    valid_reg[wr_idx] <= wr_valid;
                end
                if (gen_upd)
                begin
                    gen_reg <= gen_fresh;
                end
            end
        end
    end

    assign pick_idx  = found_reg ? found_idx_reg : (free_reg ? free_idx_reg : low_idx_reg);
    assign gen_inc   = gen_reg + 32'd1;
    assign gen_fresh = (gen_inc == 32'd0) ? 32'd1 : gen_inc;
    assign nf = req_reg.keep_frames ? found_ent_reg.frames : req_reg.frames;
    assign nr = req_reg.keep_rate ? found_ent_reg.rate : req_reg.rate;
    assign nm = req_reg.keep_mode ? found_ent_reg.mode : req_reg.mode;

    always_comb
    begin
        rsp_next  = '0;
        do_reopen = 1'b0;
        ro_idx    = pick_idx;
        ro_f      = req_reg.frames;
        ro_r      = req_reg.rate;
        ro_m      = req_reg.mode;
        wr_en     = 1'b0;
        wr_idx    = found_idx_reg;
        wr_data   = found_ent_reg;
        wr_valid  = 1'b0;
        flush     = 1'b0;
        gen_upd   = 1'b0;
        if (capture_enable)
        begin
            unique case (req_reg.operation)
                apsr_pkg::OP_OPEN:
                begin
                    do_reopen = req_reg.frames != 16'd0;
                end
                apsr_pkg::OP_LOOKUP:
                begin
                    if (found_reg)
                    begin
                        rsp_next.hit            = 1'b1;
                        rsp_next.slot_index     = 3'(found_idx_reg);
                        rsp_next.frames_out     = found_ent_reg.frames;
                        rsp_next.generation_out = found_ent_reg.generation;
                        rsp_next.mixer_action   = apsr_pkg::ACT_NONE;
                        rsp_next.rate_out       = found_ent_reg.rate;
                        rsp_next.mode_out       = found_ent_reg.mode;
                    end
                    else
                    begin
                        do_reopen = (req_reg.frames != 16'd0) && (req_reg.rate != 18'd0);
                    end
                end
                apsr_pkg::OP_CONFIG:
                begin
                    if (found_reg)
                    begin
                        if ((nr == found_ent_reg.rate) && (nm == found_ent_reg.mode))
                        begin
                            wr_en                   = 1'b1;
                            wr_valid                = 1'b1;
                            wr_data.frames          = nf;
                            rsp_next.hit            = nf != 16'd0;
                            rsp_next.slot_index     = 3'(found_idx_reg);
                            rsp_next.frames_out     = nf;
                            rsp_next.generation_out = found_ent_reg.generation;
                            rsp_next.mixer_action   = apsr_pkg::ACT_NONE;
                            rsp_next.rate_out       = nr;
                            rsp_next.mode_out       = nm;
                        end
                        else
                        begin
                            do_reopen = 1'b1;
                            ro_idx    = found_idx_reg;
                            ro_f      = nf;
                            ro_r      = nr;
                            ro_m      = nm;
                        end
                    end
                end
                apsr_pkg::OP_RELEASE:
                begin
                    if (found_reg)
                    begin
                        wr_en                 = 1'b1;
                        rsp_next.hit          = 1'b1;
                        rsp_next.slot_index   = 3'(found_idx_reg);
                        rsp_next.mixer_action = apsr_pkg::ACT_CLOSE;
                    end
                end
                apsr_pkg::OP_FLUSH:
                begin
                    flush                 = 1'b1;
                    rsp_next.mixer_action = apsr_pkg::ACT_CLOSE_ALL;
                end
                default:
                begin
                    rsp_next = '0;
                end
            endcase
        end
        if (do_reopen)
        begin
            gen_upd               = 1'b1;
            wr_en                 = 1'b1;
            wr_idx                = ro_idx;
            wr_valid              = req_reg.mixer_open_ok;
            wr_data.pid           = req_reg.process_id;
            wr_data.port          = req_reg.port_number;
            wr_data.frames        = ro_f;
            wr_data.rate          = ro_r;
            wr_data.mode          = ro_m;
            wr_data.generation    = gen_fresh;
            rsp_next.slot_index   = 3'(ro_idx);
            rsp_next.mixer_action = apsr_pkg::ACT_OPEN;
            rsp_next.rate_out     = ro_r;
            rsp_next.mode_out     = ro_m;
            if (req_reg.mixer_open_ok)
            begin
                rsp_next.hit            = ro_f != 16'd0;
                rsp_next.frames_out     = ro_f;
                rsp_next.generation_out = gen_fresh;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_END)
        else $error("Scan counter ran past the slot count.");

    a_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && gen_upd) |=> (gen_reg != 32'd0))
        else $error("A registration took a zero generation.");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && flush) |=> (valid_reg == '0))
        else $error("Flush left a slot valid.");

    a_done_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        status.scan_done |-> (cnt_reg == CNT_END))
        else $error("Scan finished before every slot was read.");

endmodule

`default_nettype wire
